@@ rtl/core/page_allocator_with_refcounts_core_assert.svh @@
// ----------------------------------------------------------------------------
// Page allocator assertion macros
// Concurrent assertion wrappers that sample on clk and are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_ALLOCATOR_WITH_REFCOUNTS_CORE_ASSERT_SVH
`define PAGE_ALLOCATOR_WITH_REFCOUNTS_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define PA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PA_ASSERT(lbl, prop, msg)
`define PA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/pgalloc_pkg.sv @@
// ----------------------------------------------------------------------------
// Page allocator package
// Sizes, codes and port structs shared by the page allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pgalloc_pkg;

    localparam int NUM_PAGES  = 32768;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W    = 32;
    localparam int KIND_W    = 3;
    localparam int STATUS_W  = 3;
    localparam int CNT_W     = 16;
    localparam int FREE_W    = 16;
    localparam int FIRST_W   = 20;
    localparam int END_W     = 21;
    localparam int CFG_W     = 21;
    localparam int CFG_IDX_W = 1;

    localparam int IDX_W  = $clog2(NUM_PAGES);
    localparam int TOP_W  = $clog2(NUM_PAGES + 1);
    localparam int PAGE_W = ADDR_W - PAGE_SHIFT;
    // Operand width of the shared unit: holds a page number, the page count
    // of the address space and the end register.
    localparam int OPND_W = (PAGE_W + 1 > END_W) ? PAGE_W + 1 : END_W;

    typedef logic [OPND_W-1:0] opnd_t;
    typedef logic [TOP_W-1:0]  top_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [PAGE_W-1:0] page_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [FREE_W-1:0] free_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam opnd_t ADDR_PAGES = opnd_t'(1) << PAGE_W;
    localparam top_t  TOP_FULL   = top_t'(NUM_PAGES);
    localparam idx_t  IDX_LAST   = idx_t'(NUM_PAGES - 1);
    localparam cnt_t  CNT_MAX    = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_INIT   = 3'd0,
        KIND_ALLOC  = 3'd1,
        KIND_FREE   = 3'd2,
        KIND_ADDREF = 3'd3,
        KIND_GETREF = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_OOM   = 3'd1,
        ST_ALIGN = 3'd2,
        ST_BAD   = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_PAGE = 1'b0,
        REG_END_PAGE   = 1'b1
    } reg_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic  we;
        idx_t  waddr;
        page_t wdata;
        logic  re;
        idx_t  raddr;
    } stack_port_t;

    typedef struct packed {
        logic we;
        idx_t waddr;
        cnt_t wdata;
        logic re;
        idx_t raddr;
    } count_port_t;

endpackage

`default_nettype wire

@@ rtl/core/pgalloc_if.sv @@
// ----------------------------------------------------------------------------
// Page allocator channel interfaces
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface pgalloc_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [pgalloc_pkg::KIND_W-1:0]       kind;
    logic [pgalloc_pkg::ADDR_W-1:0]       page_addr;

    modport source (output valid, output kind, output page_addr, input ready);
    modport sink   (input valid, input kind, input page_addr, output ready);
endinterface

interface pgalloc_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [pgalloc_pkg::STATUS_W-1:0]     status;
    logic [pgalloc_pkg::ADDR_W-1:0]       alloc_addr;
    logic [pgalloc_pkg::CNT_W-1:0]        ref_count;
    logic [pgalloc_pkg::FREE_W-1:0]       free_count;

    modport source (output valid, output status, output alloc_addr, output ref_count,
                    output free_count, input ready);
    modport sink   (input valid, input status, input alloc_addr, input ref_count,
                    input free_count, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pgalloc_alu.sv @@
// ----------------------------------------------------------------------------
// Page allocator arithmetic unit
// Shared add/subtract unit; the borrow out serves as the compare result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgalloc_alu (
    input  pgalloc_pkg::alu_op_t op,
    input  pgalloc_pkg::opnd_t   a,
    input  pgalloc_pkg::opnd_t   b,
    output pgalloc_pkg::opnd_t   y,
    output logic                 borrow
);

    logic [pgalloc_pkg::OPND_W:0] sum;

    always_comb
    begin
        case (op)
            pgalloc_pkg::ALU_ADD: sum = {1'b0, a} + {1'b0, b};
            pgalloc_pkg::ALU_SUB: sum = {1'b0, a} - {1'b0, b};
            default:              sum = '0;
        endcase
    end

    // For a subtraction the top bit is set exactly when a < b.
    assign y      = sum[pgalloc_pkg::OPND_W-1:0];
    assign borrow = sum[pgalloc_pkg::OPND_W];

endmodule

`default_nettype wire

@@ rtl/core/pgalloc_stack_mem.sv @@
// ----------------------------------------------------------------------------
// Page allocator free stack memory
// One write port and one registered read port holding free page numbers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgalloc_stack_mem (
    input  logic                     clk,
    input  pgalloc_pkg::stack_port_t port,
    output pgalloc_pkg::page_t       rdata
);

    pgalloc_pkg::page_t mem [pgalloc_pkg::NUM_PAGES];
    pgalloc_pkg::page_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (port.we)
        begin
            mem[port.waddr] <= port.wdata;
        end
        if (port.re)
        begin
            rdata_reg <= mem[port.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/pgalloc_count_mem.sv @@
// ----------------------------------------------------------------------------
// Page allocator reference count memory
// One write port and one registered read port, indexed from the first page.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pgalloc_count_mem (
    input  logic                     clk,
    input  pgalloc_pkg::count_port_t port,
    output pgalloc_pkg::cnt_t        rdata
);

    pgalloc_pkg::cnt_t mem [pgalloc_pkg::NUM_PAGES];
    pgalloc_pkg::cnt_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (port.we)
        begin
            mem[port.waddr] <= port.wdata;
        end
        if (port.re)
        begin
            rdata_reg <= mem[port.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/page_allocator_with_refcounts_core.sv @@
// ----------------------------------------------------------------------------
// Page allocator with reference counts
// LIFO free page stack plus per-page reference counts, run by a sequencer
// around one shared add/subtract unit and two one-write, one-read-port memories.
// ----------------------------------------------------------------------------
// Unknown kinds, misaligned requests and alloc on an empty stack go from idle
// straight to S_EMIT; getref, addref and free pass the range checks and a count
// read, alloc a stack pop and the range checks. Init sweeps the whole count
// store, one entry per cycle. Throughput: one transaction at a time; the memory
// reads and the three range checks through the shared unit run in turn.
// Reset: a clearing pass over all NUM_PAGES entries zeroes the counts; req.ready is low
// until it ends. Configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none
`include "page_allocator_with_refcounts_core_assert.svh"

module page_allocator_with_refcounts_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [pgalloc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pgalloc_pkg::CFG_W-1:0]         cfg_data,
    pgalloc_req_if.sink                           req,
    pgalloc_rsp_if.source                         rsp
);

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_POP,
        S_POPD,
        S_CHK_LO,
        S_CHK_HI,
        S_CHK_N,
        S_CNT,
        S_EMIT
    } state_t;

    state_t                         state_reg,      state_next;
    pgalloc_pkg::kind_t             kind_reg,       kind_next;
    pgalloc_pkg::opnd_t             page_reg,       page_next;
    pgalloc_pkg::opnd_t             diff_reg,       diff_next;
    pgalloc_pkg::opnd_t             limit_reg,      limit_next;
    pgalloc_pkg::idx_t              sweep_reg,      sweep_next;
    pgalloc_pkg::top_t              top_reg,        top_next;
    logic                           clear_only_reg, clear_only_next;
    logic [pgalloc_pkg::FIRST_W-1:0] first_reg,     first_next;
    logic [pgalloc_pkg::END_W-1:0]  end_reg,        end_next;
    pgalloc_pkg::status_t           res_status_reg, res_status_next;
    pgalloc_pkg::addr_t             res_addr_reg,   res_addr_next;
    pgalloc_pkg::cnt_t              res_cnt_reg,    res_cnt_next;
    logic                           out_valid_reg,  out_valid_next;
    pgalloc_pkg::status_t           out_status_reg, out_status_next;
    pgalloc_pkg::addr_t             out_addr_reg,   out_addr_next;
    pgalloc_pkg::cnt_t              out_cnt_reg,    out_cnt_next;
    pgalloc_pkg::free_t             out_free_reg,   out_free_next;

    pgalloc_pkg::stack_port_t       stack_port;
    pgalloc_pkg::count_port_t       count_port;
    pgalloc_pkg::page_t             stack_rdata;
    pgalloc_pkg::cnt_t              count_rdata;

    pgalloc_pkg::alu_op_t           alu_op;
    pgalloc_pkg::opnd_t             alu_a;
    pgalloc_pkg::opnd_t             alu_b;
    pgalloc_pkg::opnd_t             alu_y;
    logic                           alu_borrow;

    logic                           in_fire;
    logic                           can_emit;
    pgalloc_pkg::opnd_t             first_opnd;
    pgalloc_pkg::opnd_t             end_opnd;
    pgalloc_pkg::cnt_t              cnt_new;

    pgalloc_alu u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .y      (alu_y),
        .borrow (alu_borrow)
    );

    pgalloc_stack_mem u_stack_mem (
        .clk   (clk),
        .port  (stack_port),
        .rdata (stack_rdata)
    );

    pgalloc_count_mem u_count_mem (
        .clk   (clk),
        .port  (count_port),
        .rdata (count_rdata)
    );

    assign req.ready      = (state_reg == S_IDLE);
    assign in_fire        = req.valid && req.ready;
    assign can_emit       = !out_valid_reg || rsp.ready;
    assign first_opnd     = pgalloc_pkg::opnd_t'(first_reg);
    assign end_opnd       = pgalloc_pkg::opnd_t'(end_reg);

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.alloc_addr = out_addr_reg;
    assign rsp.ref_count  = out_cnt_reg;
    assign rsp.free_count = out_free_reg;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        page_next       = page_reg;
        diff_next       = diff_reg;
        limit_next      = limit_reg;
        sweep_next      = sweep_reg;
        top_next        = top_reg;
        clear_only_next = clear_only_reg;
        first_next      = first_reg;
        end_next        = end_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_cnt_next    = res_cnt_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_cnt_next    = out_cnt_reg;
        out_free_next   = out_free_reg;
        stack_port      = '0;
        count_port      = '0;
        alu_op          = pgalloc_pkg::ALU_ADD;
        alu_a           = '0;
        alu_b           = '0;
        cnt_new         = count_rdata;

        if (cfg_we)
        begin
            unique case (pgalloc_pkg::reg_t'(cfg_index))
                pgalloc_pkg::REG_FIRST_PAGE: first_next = cfg_data[pgalloc_pkg::FIRST_W-1:0];
                pgalloc_pkg::REG_END_PAGE:   end_next   = cfg_data[pgalloc_pkg::END_W-1:0];
                default:                     end_next   = end_reg;
            endcase
        end

        unique case (state_reg)
            S_SWEEP:
            begin
                count_port.we    = 1'b1;
                count_port.waddr = sweep_reg;
                count_port.wdata = '0;
                alu_op           = pgalloc_pkg::ALU_SUB;
                alu_a            = page_reg;
                alu_b            = limit_reg;
                if (!clear_only_reg && alu_borrow)
                begin
                    stack_port.we    = 1'b1;
                    stack_port.waddr = sweep_reg;
                    stack_port.wdata = page_reg[pgalloc_pkg::PAGE_W-1:0];
                    top_next         = pgalloc_pkg::top_t'(sweep_reg) + pgalloc_pkg::top_t'(1);
                end
                page_next  = page_reg + pgalloc_pkg::opnd_t'(1);
                sweep_next = sweep_reg + pgalloc_pkg::idx_t'(1);
                if (sweep_reg == pgalloc_pkg::IDX_LAST)
                begin
                    state_next = clear_only_reg ? S_IDLE : S_EMIT;
                end
            end

            S_IDLE:
            begin
                if (in_fire)
                begin
                    kind_next       = pgalloc_pkg::kind_t'(req.kind);
                    page_next       = pgalloc_pkg::opnd_t'(
                                          req.page_addr[pgalloc_pkg::ADDR_W-1:pgalloc_pkg::PAGE_SHIFT]);
                    res_status_next = pgalloc_pkg::ST_OK;
                    res_addr_next   = '0;
                    res_cnt_next    = '0;
                    unique case (pgalloc_pkg::kind_t'(req.kind)) inside
                        pgalloc_pkg::KIND_INIT:
                        begin
                            // Pages whose byte address does not fit are never pushed.
                            limit_next      = (end_opnd > pgalloc_pkg::ADDR_PAGES) ?
                                              pgalloc_pkg::ADDR_PAGES : end_opnd;
                            page_next       = first_opnd;
                            sweep_next      = '0;
                            top_next        = '0;
                            clear_only_next = 1'b0;
                            state_next      = S_SWEEP;
                        end
                        pgalloc_pkg::KIND_ALLOC:
                        begin
                            if (top_reg == '0)
                            begin
                                res_status_next = pgalloc_pkg::ST_OOM;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                        pgalloc_pkg::KIND_FREE, pgalloc_pkg::KIND_ADDREF,
                        pgalloc_pkg::KIND_GETREF:
                        begin
                            if (|req.page_addr[pgalloc_pkg::PAGE_SHIFT-1:0])
                            begin
                                res_status_next = pgalloc_pkg::ST_ALIGN;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_CHK_LO;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            S_POP:
            begin
                alu_op           = pgalloc_pkg::ALU_SUB;
                alu_a            = pgalloc_pkg::opnd_t'(top_reg);
                alu_b            = pgalloc_pkg::opnd_t'(1);
                top_next         = alu_y[pgalloc_pkg::TOP_W-1:0];
                stack_port.re    = 1'b1;
                stack_port.raddr = alu_y[pgalloc_pkg::IDX_W-1:0];
                state_next       = S_POPD;
            end

            S_POPD:
            begin
                page_next     = pgalloc_pkg::opnd_t'(stack_rdata);
                res_addr_next = {stack_rdata, {pgalloc_pkg::PAGE_SHIFT{1'b0}}};
                state_next    = S_CHK_LO;
            end

            S_CHK_LO, S_CHK_HI, S_CHK_N:
            begin
                alu_op = pgalloc_pkg::ALU_SUB;
                if (state_reg == S_CHK_LO)
                begin
                    alu_a = page_reg;
                    alu_b = first_opnd;
                end
                else if (state_reg == S_CHK_HI)
                begin
                    alu_a = page_reg;
                    alu_b = end_opnd;
                end
                else
                begin
                    alu_a = diff_reg;
                    alu_b = pgalloc_pkg::opnd_t'(pgalloc_pkg::NUM_PAGES);
                end

                // Below the first page needs a borrow to fail; the upper checks
                // need one to pass.
                if ((state_reg == S_CHK_LO) == alu_borrow)
                begin
                    // A popped page outside the count range is still handed out.
                    if (kind_reg != pgalloc_pkg::KIND_ALLOC)
                    begin
                        res_status_next = pgalloc_pkg::ST_BAD;
                    end
                    state_next = S_EMIT;
                end
                else if (state_reg == S_CHK_LO)
                begin
                    diff_next  = alu_y;
                    state_next = S_CHK_HI;
                end
                else if (state_reg == S_CHK_HI)
                begin
                    state_next = S_CHK_N;
                end
                else if (kind_reg == pgalloc_pkg::KIND_ALLOC)
                begin
                    count_port.we    = 1'b1;
                    count_port.waddr = diff_reg[pgalloc_pkg::IDX_W-1:0];
                    count_port.wdata = pgalloc_pkg::cnt_t'(1);
                    res_cnt_next     = pgalloc_pkg::cnt_t'(1);
                    state_next       = S_EMIT;
                end
                else
                begin
                    count_port.re    = 1'b1;
                    count_port.raddr = diff_reg[pgalloc_pkg::IDX_W-1:0];
                    state_next       = S_CNT;
                end
            end

            S_CNT:
            begin
                count_port.waddr = diff_reg[pgalloc_pkg::IDX_W-1:0];
                unique case (kind_reg) inside
                    pgalloc_pkg::KIND_GETREF:
                    begin
                        res_cnt_next = count_rdata;
                    end
                    pgalloc_pkg::KIND_ADDREF:
                    begin
                        alu_a            = pgalloc_pkg::opnd_t'(count_rdata);
                        alu_b            = pgalloc_pkg::opnd_t'(1);
                        cnt_new          = (count_rdata == pgalloc_pkg::CNT_MAX) ?
                                           count_rdata : alu_y[pgalloc_pkg::CNT_W-1:0];
                        count_port.we    = 1'b1;
                        count_port.wdata = cnt_new;
                        res_cnt_next     = cnt_new;
                    end
                    pgalloc_pkg::KIND_FREE:
                    begin
                        if (|count_rdata[pgalloc_pkg::CNT_W-1:1])
                        begin
                            // Shared page: drop one reference only.
                            alu_op           = pgalloc_pkg::ALU_SUB;
                            alu_a            = pgalloc_pkg::opnd_t'(count_rdata);
                            alu_b            = pgalloc_pkg::opnd_t'(1);
                            count_port.we    = 1'b1;
                            count_port.wdata = alu_y[pgalloc_pkg::CNT_W-1:0];
                            res_cnt_next     = alu_y[pgalloc_pkg::CNT_W-1:0];
                        end
                        else if (top_reg == pgalloc_pkg::TOP_FULL)
                        begin
                            res_status_next = pgalloc_pkg::ST_FULL;
                            res_cnt_next    = count_rdata;
                        end
                        else
                        begin
                            count_port.we    = 1'b1;
                            count_port.wdata = '0;
                            stack_port.we    = 1'b1;
                            stack_port.waddr = top_reg[pgalloc_pkg::IDX_W-1:0];
                            stack_port.wdata = page_reg[pgalloc_pkg::PAGE_W-1:0];
                            alu_a            = pgalloc_pkg::opnd_t'(top_reg);
                            alu_b            = pgalloc_pkg::opnd_t'(1);
                            top_next         = alu_y[pgalloc_pkg::TOP_W-1:0];
                        end
                    end
                    default:
                    begin
                        res_cnt_next = '0;
                    end
                endcase
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_cnt_next    = res_cnt_reg;
                    out_free_next   = pgalloc_pkg::free_t'(top_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            kind_reg       <= pgalloc_pkg::KIND_INIT;
            page_reg       <= '0;
            diff_reg       <= '0;
            limit_reg      <= '0;
            sweep_reg      <= '0;
            top_reg        <= '0;
            clear_only_reg <= 1'b1;
            first_reg      <= '0;
            end_reg        <= pgalloc_pkg::END_W'(32768);
            res_status_reg <= pgalloc_pkg::ST_OK;
            res_addr_reg   <= '0;
            res_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= pgalloc_pkg::ST_OK;
            out_addr_reg   <= '0;
            out_cnt_reg    <= '0;
            out_free_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            page_reg       <= page_next;
            diff_reg       <= diff_next;
            limit_reg      <= limit_next;
            sweep_reg      <= sweep_next;
            top_reg        <= top_next;
            clear_only_reg <= clear_only_next;
            first_reg      <= first_next;
            end_reg        <= end_next;
            res_status_reg <= res_status_next;
            res_addr_reg   <= res_addr_next;
            res_cnt_reg    <= res_cnt_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_addr_reg   <= out_addr_next;
            out_cnt_reg    <= out_cnt_next;
            out_free_reg   <= out_free_next;
        end
    end

    `PA_ASSERT(a_top_bound, top_reg <= pgalloc_pkg::TOP_FULL, "free count above stack depth")
    `PA_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_reg != S_IDLE, "accepted request not started")
    `PA_ASSERT(a_valid_from_emit, $rose(out_valid_reg) |-> $past(state_reg) == S_EMIT, "response without emit")
    `PA_ASSERT_NEXT(a_emit_loads, state_reg == S_EMIT && can_emit, out_valid_reg && state_reg == S_IDLE, "emit did not load response")
    `PA_ASSERT(a_top_step, (state_reg != S_SWEEP && $past(state_reg) != S_SWEEP) |-> (top_reg == $past(top_reg) || top_reg == $past(top_reg) + 1'b1 || top_reg == $past(top_reg) - 1'b1), "free count jumped by more than one")

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page allocator with reference counts: self-checking regression
// Drives init, alloc, free, addref and getref requests plus malformed and
// unknown ones through the request channel, predicts every response with a
// behavioral copy of the free stack and count store, and compares each
// response field by field. Both channel sides idle at random except in the last
// two phases; one long response hold-off fills the block and stalls its input.
// ----------------------------------------------------------------------------

module testbench;

    import pgalloc_pkg::*;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        addr_t             addr;
    } page_req_t;

    typedef struct packed {
        status_t status;
        addr_t   alloc_addr;
        cnt_t    ref_count;
        free_t   free_count;
    } page_rsp_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    pgalloc_req_if req_ch ();
    pgalloc_rsp_if rsp_ch ();

    page_allocator_with_refcounts_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // Behavioral copy of the allocator state and its window registers.
    page_t       free_pages [NUM_PAGES];
    cnt_t        page_refs [NUM_PAGES];
    int unsigned free_depth = 0;
    int unsigned win_first = 0;
    int unsigned win_end = NUM_PAGES;

    page_req_t   request_q [$];
    page_rsp_t   expected_rsp_q [$];
    page_rsp_t   exp_rsp;

    int          n_queued = 0;
    int          n_accepted = 0;
    int          n_done = 0;
    int          n_errors = 0;
    int          send_idle_pct = 17;
    int          recv_idle_pct = 85;
    logic        req_taken = 1'b0;
    logic        rsp_hold = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        if (n_errors < 100)
            $display("ERROR at %0t ns: %s", $time, msg);
        n_errors++;
    endtask

    // Count store slot of a page number; zero return when it has none.
    function automatic bit count_slot(input int unsigned page, output int unsigned slot);
        slot = 0;
        if (page < win_first || page >= win_end)
            return 1'b0;
        if (page - win_first >= NUM_PAGES)
            return 1'b0;
        slot = page - win_first;
        return 1'b1;
    endfunction

    function automatic status_t check_page_addr(input addr_t addr, output int unsigned slot);
        slot = 0;
        if (addr[PAGE_SHIFT-1:0] != '0)
            return ST_ALIGN;
        if (!count_slot(addr >> PAGE_SHIFT, slot))
            return ST_BAD;
        return ST_OK;
    endfunction

    function automatic void apply_request(input logic [KIND_W-1:0] kind, input addr_t addr);
        page_rsp_t   r;
        int unsigned slot;
        int unsigned pg;
        int unsigned limit;
        r = '{status: ST_OK, alloc_addr: '0, ref_count: '0, free_count: '0};
        case (kind)
            KIND_INIT:
            begin
                foreach (page_refs[i])
                    page_refs[i] = '0;
                free_depth = 0;
                limit = win_end;
                if (limit > (1 << PAGE_W))
                    limit = 1 << PAGE_W;
                for (pg = win_first; pg < limit && free_depth < NUM_PAGES; pg++)
                begin
                    free_pages[free_depth] = page_t'(pg);
                    free_depth++;
                end
            end
            KIND_ALLOC:
            begin
                if (free_depth == 0)
                    r.status = ST_OOM;
                else
                begin
                    free_depth--;
                    pg = free_pages[free_depth];
                    r.alloc_addr = addr_t'(pg) << PAGE_SHIFT;
                    if (count_slot(pg, slot))
                    begin
                        page_refs[slot] = cnt_t'(1);
                        r.ref_count = cnt_t'(1);
                    end
                end
            end
            KIND_FREE:
            begin
                r.status = check_page_addr(addr, slot);
                if (r.status == ST_OK)
                begin
                    if (page_refs[slot] > cnt_t'(1))
                    begin
                        page_refs[slot]--;
                        r.ref_count = page_refs[slot];
                    end
                    else if (free_depth >= NUM_PAGES)
                    begin
                        r.status = ST_FULL;
                        r.ref_count = page_refs[slot];
                    end
                    else
                    begin
                        // A page with a zero count goes back on the stack again.
                        page_refs[slot] = '0;
                        free_pages[free_depth] = page_t'(addr >> PAGE_SHIFT);
                        free_depth++;
                    end
                end
            end
            KIND_ADDREF:
            begin
                r.status = check_page_addr(addr, slot);
                if (r.status == ST_OK)
                begin
                    if (page_refs[slot] != CNT_MAX)
                        page_refs[slot]++;
                    r.ref_count = page_refs[slot];
                end
            end
            KIND_GETREF:
            begin
                r.status = check_page_addr(addr, slot);
                if (r.status == ST_OK)
                    r.ref_count = page_refs[slot];
            end
            default:
            begin
            end
        endcase
        r.free_count = free_t'(free_depth);
        expected_rsp_q.push_back(r);
    endfunction

    // Aligned address of a page inside the current window, or of any page when the window is empty.
    function automatic addr_t window_addr();
        int unsigned span;
        span = (win_end > win_first) ? win_end - win_first : 0;
        if (span > NUM_PAGES)
            span = NUM_PAGES;
        if (span == 0)
            return addr_t'($urandom_range(0, (1 << PAGE_W) - 1)) << PAGE_SHIFT;
        return addr_t'(win_first + $urandom_range(0, span - 1)) << PAGE_SHIFT;
    endfunction

    function automatic logic [KIND_W-1:0] page_op();
        case ($urandom_range(0, 2))
            0:       return KIND_FREE;
            1:       return KIND_ADDREF;
            default: return KIND_GETREF;
        endcase
    endfunction

    task automatic push_req(input logic [KIND_W-1:0] kind, input addr_t addr);
        request_q.push_back('{kind: kind, addr: addr});
        n_queued++;
    endtask

    // Registers are only written once every queued request has its response.
    task automatic write_reg(input reg_t index, input logic [CFG_W-1:0] value);
        wait (n_queued == n_done);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        if (index == REG_FIRST_PAGE)
            win_first = value[FIRST_W-1:0];
        else
            win_end = value[END_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input int p);
        int unsigned first_pg;
        int unsigned span;
        int unsigned last_pg;
        int unsigned shifted;
        int unsigned bad_pg;
        int          r;
        span = $urandom_range(1, 48);
        case (p % 3)
            0:       first_pg = $urandom_range(0, 64);
            1:       first_pg = $urandom_range(0, (1 << PAGE_W) - 64);
            default: first_pg = (1 << PAGE_W) - span;
        endcase
        last_pg = first_pg + span;
        write_reg(REG_FIRST_PAGE, CFG_W'(first_pg));
        write_reg(REG_END_PAGE, CFG_W'(last_pg));
        push_req(KIND_INIT, $urandom());
        for (int i = 0; i < 165; i++)
        begin
            // Odd phases move the window after init, so popped pages may fall outside.
            if (i == 80 && p % 2 == 1)
            begin
                shifted = first_pg + $urandom_range(1, span);
                if (shifted > (1 << PAGE_W) - 1)
                    shifted = (1 << PAGE_W) - 1;
                write_reg(REG_FIRST_PAGE, CFG_W'(shifted));
                if (p == 7 && last_pg + 4 <= (1 << PAGE_W))
                    write_reg(REG_END_PAGE, CFG_W'(last_pg + 4));
            end
            if (i == 100 && (p == 2 || p == 5))
                push_req(KIND_INIT, $urandom());
            r = $urandom_range(0, 99);
            if (r < 30)
                push_req(KIND_ALLOC, $urandom());
            else if (r < 55)
                push_req(KIND_FREE, window_addr());
            else if (r < 68)
                push_req(KIND_ADDREF, window_addr());
            else if (r < 82)
                push_req(KIND_GETREF, window_addr());
            else if (r < 86)
                push_req(page_op(),
                         window_addr() | addr_t'($urandom_range(1, (1 << PAGE_SHIFT) - 1)));
            else if (r < 92)
            begin
                case ($urandom_range(0, 2))
                    0:       bad_pg = win_first - 1;
                    1:       bad_pg = win_end;
                    default: bad_pg = $urandom();
                endcase
                push_req(page_op(), addr_t'(bad_pg & ((1 << PAGE_W) - 1)) << PAGE_SHIFT);
            end
            else if (r < 96)
                push_req(page_op(), $urandom());
            else
                push_req(KIND_W'($urandom_range(int'(KIND_GETREF) + 1, (1 << KIND_W) - 1)),
                         $urandom());
        end
    endtask

    // Request driver: a transaction stays offered until it is accepted.
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            apply_request(req_ch.kind, req_ch.page_addr);
            req_taken = 1'b1;
            n_accepted++;
        end
    end

    always @(negedge clk)
    begin
        page_req_t item;
        if (!req_ch.valid || req_taken)
        begin
            req_taken = 1'b0;
            if (rst_n && request_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                item = request_q.pop_front();
                req_ch.valid <= 1'b1;
                req_ch.kind <= item.kind;
                req_ch.page_addr <= item.addr;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        rsp_ch.ready <= !rsp_hold && $urandom_range(0, 99) >= recv_idle_pct;
    end

    // Response monitor.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_rsp_q.size() == 0)
                flag_error("response transaction with nothing expected");
            else
            begin
                exp_rsp = expected_rsp_q.pop_front();
                if (rsp_ch.status !== exp_rsp.status)
                    flag_error($sformatf("response %0d status: expected %0d, got %0d",
                                         n_done, exp_rsp.status, rsp_ch.status));
                if (rsp_ch.alloc_addr !== exp_rsp.alloc_addr)
                    flag_error($sformatf("response %0d alloc_addr: expected %h, got %h",
                                         n_done, exp_rsp.alloc_addr, rsp_ch.alloc_addr));
                if (rsp_ch.ref_count !== exp_rsp.ref_count)
                    flag_error($sformatf("response %0d ref_count: expected %0d, got %0d",
                                         n_done, exp_rsp.ref_count, rsp_ch.ref_count));
                if (rsp_ch.free_count !== exp_rsp.free_count)
                    flag_error($sformatf("response %0d free_count: expected %0d, got %0d",
                                         n_done, exp_rsp.free_count, rsp_ch.free_count));
                n_done++;
            end
        end
    end

    // One long response stall while requests keep coming.
    initial
    begin
        wait (n_accepted >= 500);
        rsp_hold = 1'b1;
        repeat (400) @(posedge clk);
        rsp_hold = 1'b0;
    end

    initial
    begin
        #30_000_000;
        $display("page_allocator_with_refcounts_core regression: fail");
        $finish;
    end

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_INIT;
        req_ch.page_addr = '0;
        rsp_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FIRST_PAGE;
        cfg_data = '0;
        foreach (page_refs[i])
            page_refs[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Full window: stack fills completely, then shared and double frees.
        write_reg(REG_FIRST_PAGE, CFG_W'(0));
        write_reg(REG_END_PAGE, CFG_W'(NUM_PAGES));
        push_req(KIND_INIT, $urandom());
        push_req(KIND_FREE, addr_t'(5) << PAGE_SHIFT);
        push_req(KIND_ALLOC, $urandom());
        push_req(KIND_ADDREF, addr_t'(NUM_PAGES - 1) << PAGE_SHIFT);
        push_req(KIND_FREE, addr_t'(NUM_PAGES - 1) << PAGE_SHIFT);
        push_req(KIND_GETREF, addr_t'(NUM_PAGES - 1) << PAGE_SHIFT);
        push_req(KIND_FREE, addr_t'(NUM_PAGES - 1) << PAGE_SHIFT);
        push_req(KIND_ALLOC, $urandom());
        push_req(KIND_ALLOC, $urandom());
        push_req(KIND_FREE, addr_t'(NUM_PAGES - 2) << PAGE_SHIFT);
        push_req(KIND_FREE, addr_t'(NUM_PAGES - 2) << PAGE_SHIFT);
        push_req(KIND_FREE, (addr_t'(NUM_PAGES - 2) << PAGE_SHIFT) | addr_t'(4));
        push_req(KIND_ADDREF, addr_t'(32'h0000_0800));
        push_req(KIND_GETREF, addr_t'(NUM_PAGES) << PAGE_SHIFT);
        push_req(KIND_W'((1 << KIND_W) - 1), '1);

        // Single page at the very top of the address space.
        write_reg(REG_FIRST_PAGE, CFG_W'((1 << PAGE_W) - 1));
        write_reg(REG_END_PAGE, CFG_W'(1 << PAGE_W));
        push_req(KIND_INIT, $urandom());
        push_req(KIND_ALLOC, $urandom());
        push_req(KIND_ALLOC, $urandom());
        push_req(KIND_GETREF, addr_t'((1 << PAGE_W) - 2) << PAGE_SHIFT);
        push_req(KIND_GETREF, addr_t'((1 << PAGE_W) - 1) << PAGE_SHIFT);
        push_req(KIND_FREE, addr_t'((1 << PAGE_W) - 1) << PAGE_SHIFT);

        // Window moved after init: the stacked page has no count slot any more.
        write_reg(REG_FIRST_PAGE, CFG_W'(0));
        push_req(KIND_ALLOC, $urandom());
        push_req(KIND_FREE, addr_t'((1 << PAGE_W) - 1) << PAGE_SHIFT);

        // Oversized window is cut to the stack size; then an empty window.
        write_reg(REG_END_PAGE, CFG_W'(1 << PAGE_W));
        push_req(KIND_INIT, $urandom());
        push_req(KIND_ALLOC, $urandom());
        write_reg(REG_END_PAGE, CFG_W'(0));
        push_req(KIND_INIT, $urandom());
        push_req(KIND_ALLOC, $urandom());

        for (int p = 0; p < 8; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 17;
            end
            else if (p == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_phase(p);
        end

        wait (n_queued == n_done);
        repeat (40) @(posedge clk);
        if (expected_rsp_q.size() != 0)
            flag_error($sformatf("%0d expected responses never arrived",
                                 expected_rsp_q.size()));
        if (n_errors == 0)
            $display("page_allocator_with_refcounts_core regression: pass");
        else
            $display("page_allocator_with_refcounts_core regression: fail");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/pgalloc_pkg.sv
rtl/core/pgalloc_if.sv
rtl/core/pgalloc_alu.sv
rtl/core/pgalloc_stack_mem.sv
rtl/core/pgalloc_count_mem.sv
rtl/core/page_allocator_with_refcounts_core.sv
sim/testbench.sv
